FILE: rtl/cbpc_pkg.sv
// Shared types, constants and helper functions for the column base profile counter.
package cbpc_pkg;

    // Store geometry and word widths
    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int QCOL_W          = 10;
    localparam int CNT_W           = 16;
    localparam int TOTAL_W         = 18;
    localparam int FRAC_SHIFT      = 8;
    localparam int FRAC_BASE_W     = 9;
    localparam int FRAC_W          = 16;
    localparam int NUM_W           = CNT_W + FRAC_SHIFT;
    localparam int DEN_W           = TOTAL_W;
    localparam int NUM_BINS        = 5;

    // Command codes on the mode field
    localparam logic [1:0] MODE_SYMBOL = 2'd0;
    localparam logic [1:0] MODE_EOL    = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // ASCII codes of interest
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_C       = 8'h43;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_T       = 8'h54;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // Count bins, also used as the divider sequence index
    typedef enum logic [2:0] {
        BIN_A,
        BIN_C,
        BIN_G,
        BIN_T,
        BIN_OTHER
    } t_bin;

    // One memory word: the five counts of one column
    typedef struct packed {
        logic [CNT_W-1:0] cnt_a;
        logic [CNT_W-1:0] cnt_c;
        logic [CNT_W-1:0] cnt_g;
        logic [CNT_W-1:0] cnt_t;
        logic [CNT_W-1:0] cnt_o;
    } t_counts;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_QREAD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_REPORT
    } t_state;

    // Fold lower case letters and sort the byte into a bin
    function automatic t_bin classify(input logic [7:0] sym);
        logic [7:0] folded;
        t_bin       bin;
        begin
            folded = sym;
            if (sym >= CH_LOWER_A && sym <= CH_LOWER_Z) begin
                folded = sym & ~CASE_BIT;
            end
            case (folded)
                CH_A:    bin = BIN_A;
                CH_C:    bin = BIN_C;
                CH_G:    bin = BIN_G;
                CH_T:    bin = BIN_T;
                default: bin = BIN_OTHER;
            endcase
            return bin;
        end
    endfunction

    // Saturating increment of a count
    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] val);
        begin
            return (val == {CNT_W{1'b1}}) ? val : CNT_W'(val + 1'b1);
        end
    endfunction

    // Clamp a quotient to the fraction width
    function automatic logic [FRAC_W-1:0] sat_frac(input logic [NUM_W-1:0] quot);
        begin
            return (|quot[NUM_W-1:FRAC_W]) ? {FRAC_W{1'b1}} : quot[FRAC_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/cbpc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module cbpc_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/cbpc_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module cbpc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cbpc_pkg::NUM_W-1:0]     i_num,
    input  logic [cbpc_pkg::DEN_W-1:0]     i_den,
    output logic                           o_done,
    output logic [cbpc_pkg::NUM_W-1:0]     o_quot
);

    localparam int NUM_W  = cbpc_pkg::NUM_W;
    localparam int DEN_W  = cbpc_pkg::DEN_W;
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_quo;

    logic [DEN_W:0]    w_shift;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;
    logic [DEN_W-1:0]  n_rem;

    // Trial subtraction of one step
    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = (w_shift >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: rtl/column_base_profile_counter_top.sv
// Per-column A/C/G/T/other counter over a text stream, with column queries.
// Symbol and end-of-line words are taken every cycle when not busy: one read-modify-write
// of the count memory per symbol, with write forwarding between back-to-back accesses.
// A query strobes its result in the REPORT state after QREAD and the divisions (none
// when the base total is zero): five 24-step divisions in one shared divider hold busy.
// After reset a clearing pass writes zero to every column, with busy high.
module column_base_profile_counter_top #(
    parameter int MAX_COLUMNS = cbpc_pkg::DEF_MAX_COLUMNS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_mode,
    input  logic [7:0]                           i_symbol,
    input  logic [cbpc_pkg::QCOL_W-1:0]          i_query_column,
    output logic                                 o_valid,
    output logic [cbpc_pkg::CNT_W-1:0]           o_count_a,
    output logic [cbpc_pkg::CNT_W-1:0]           o_count_c,
    output logic [cbpc_pkg::CNT_W-1:0]           o_count_g,
    output logic [cbpc_pkg::CNT_W-1:0]           o_count_t,
    output logic [cbpc_pkg::CNT_W-1:0]           o_count_other,
    output logic [cbpc_pkg::TOTAL_W-1:0]         o_base_total,
    output logic [cbpc_pkg::FRAC_BASE_W-1:0]     o_frac_a,
    output logic [cbpc_pkg::FRAC_BASE_W-1:0]     o_frac_c,
    output logic [cbpc_pkg::FRAC_BASE_W-1:0]     o_frac_g,
    output logic [cbpc_pkg::FRAC_BASE_W-1:0]     o_frac_t,
    output logic [cbpc_pkg::FRAC_W-1:0]          o_frac_other,
    output logic                                 o_in_last_line
);

    localparam int AW     = $clog2(MAX_COLUMNS);
    localparam int PW     = $clog2(MAX_COLUMNS + 1);
    localparam int CW     = (PW > cbpc_pkg::QCOL_W) ? PW : cbpc_pkg::QCOL_W;
    localparam int WORD_W = $bits(cbpc_pkg::t_counts);

    cbpc_pkg::t_state r_state, n_state;

    // Column tracking
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_last_len;
    logic [AW-1:0] r_clr_addr;

    // Second stage (memory data return)
    logic             r_s2_valid;
    logic             r_s2_is_upd;
    logic [AW-1:0]    r_s2_addr;
    cbpc_pkg::t_bin   r_s2_bin;
    logic             r_s2_in_range;

    // Forwarding of the word written in the read cycle
    logic             r_fwd_valid;
    logic [AW-1:0]    r_fwd_addr;
    cbpc_pkg::t_counts r_fwd_data;

    // Query result registers
    cbpc_pkg::t_counts              r_cnt;
    logic [cbpc_pkg::TOTAL_W-1:0]   r_total;
    logic [cbpc_pkg::FRAC_W-1:0]    r_frac [cbpc_pkg::NUM_BINS];
    logic                           r_in_last;
    cbpc_pkg::t_bin                 r_div_idx;

    logic                           w_accept;
    logic                           w_is_sym;
    logic                           w_is_eol;
    logic                           w_is_query;
    logic                           w_pos_ok;
    logic [CW-1:0]                  w_qext;
    logic                           w_q_in_range;
    logic [AW-1:0]                  w_rd_addr;
    logic [WORD_W-1:0]              w_rd_raw;
    cbpc_pkg::t_counts              w_rd;
    cbpc_pkg::t_counts              w_rd_masked;
    cbpc_pkg::t_counts              w_upd;
    logic                           w_wr_en;
    logic [AW-1:0]                  w_wr_addr;
    cbpc_pkg::t_counts              w_wr_data;
    logic [cbpc_pkg::TOTAL_W-1:0]   w_sum;
    logic                           w_div_start;
    logic                           w_div_done;
    logic [cbpc_pkg::NUM_W-1:0]     w_div_quot;
    logic [cbpc_pkg::CNT_W-1:0]     w_div_cnt;
    logic                           w_clr_last;

    // Command decode
    assign busy         = (r_state != cbpc_pkg::ST_RUN);
    assign w_accept     = start && !busy;
    assign w_is_sym     = (i_mode == cbpc_pkg::MODE_SYMBOL);
    assign w_is_eol     = (i_mode == cbpc_pkg::MODE_EOL);
    assign w_is_query   = (i_mode == cbpc_pkg::MODE_QUERY);
    assign w_pos_ok     = (r_pos < PW'(MAX_COLUMNS));
    assign w_qext       = CW'(i_query_column);
    assign w_q_in_range = (w_qext < CW'(MAX_COLUMNS));
    assign w_rd_addr    = w_is_query ? AW'(w_qext) : r_pos[AW-1:0];
    assign w_clr_last   = (r_clr_addr == AW'(MAX_COLUMNS - 1));

    // Count memory
    cbpc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_COLUMNS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    // Read data with forwarding of a same-column write
    always_comb begin
        w_rd = cbpc_pkg::t_counts'(w_rd_raw);
        if (r_fwd_valid && (r_fwd_addr == r_s2_addr)) begin
            w_rd = r_fwd_data;
        end
        w_rd_masked = r_s2_in_range ? w_rd : '0;
        w_sum = cbpc_pkg::TOTAL_W'(w_rd_masked.cnt_a) + cbpc_pkg::TOTAL_W'(w_rd_masked.cnt_c)
              + cbpc_pkg::TOTAL_W'(w_rd_masked.cnt_g) + cbpc_pkg::TOTAL_W'(w_rd_masked.cnt_t);
    end

    // Increment the selected count
    always_comb begin
        w_upd = w_rd;
        case (r_s2_bin)
            cbpc_pkg::BIN_A:     w_upd.cnt_a = cbpc_pkg::inc_sat(w_rd.cnt_a);
            cbpc_pkg::BIN_C:     w_upd.cnt_c = cbpc_pkg::inc_sat(w_rd.cnt_c);
            cbpc_pkg::BIN_G:     w_upd.cnt_g = cbpc_pkg::inc_sat(w_rd.cnt_g);
            cbpc_pkg::BIN_T:     w_upd.cnt_t = cbpc_pkg::inc_sat(w_rd.cnt_t);
            default:             w_upd.cnt_o = cbpc_pkg::inc_sat(w_rd.cnt_o);
        endcase
    end

    // Write port: clearing pass or count update
    always_comb begin
        if (r_state == cbpc_pkg::ST_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = '0;
        end else begin
            w_wr_en   = r_s2_valid && r_s2_is_upd;
            w_wr_addr = r_s2_addr;
            w_wr_data = w_upd;
        end
    end

    // Forwarding registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= w_wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= w_wr_addr;
        r_fwd_data <= w_wr_data;
    end

    // Column position, line length and clearing address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_last_len <= '0;
            r_clr_addr <= '0;
        end else begin
            if (r_state == cbpc_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_accept && w_is_sym && w_pos_ok) begin
                r_pos <= r_pos + 1'b1;
            end else if (w_accept && w_is_eol) begin
                r_last_len <= r_pos;
                r_pos      <= '0;
            end
        end
    end

    // Second stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= w_accept && ((w_is_sym && w_pos_ok) || w_is_query);
        end
    end

    // Second stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s2_is_upd   <= w_is_sym;
            r_s2_addr     <= w_rd_addr;
            r_s2_bin      <= cbpc_pkg::classify(i_symbol);
            r_s2_in_range <= w_is_sym || w_q_in_range;
        end
        if (w_accept && w_is_query) begin
            r_in_last <= (w_qext < CW'(r_last_len));
        end
    end

    // Controller state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbpc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and divider launch
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        case (r_state)
            cbpc_pkg::ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = cbpc_pkg::ST_RUN;
                end
            end
            cbpc_pkg::ST_RUN: begin
                if (w_accept && w_is_query) begin
                    n_state = cbpc_pkg::ST_QREAD;
                end
            end
            cbpc_pkg::ST_QREAD: begin
                n_state = cbpc_pkg::ST_DIV_GO;
            end
            cbpc_pkg::ST_DIV_GO: begin
                if (r_total == '0) begin
                    n_state = cbpc_pkg::ST_REPORT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = cbpc_pkg::ST_DIV_WAIT;
                end
            end
            cbpc_pkg::ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_div_idx == cbpc_pkg::BIN_OTHER) ? cbpc_pkg::ST_REPORT
                                                                 : cbpc_pkg::ST_DIV_GO;
                end
            end
            cbpc_pkg::ST_REPORT: begin
                n_state = cbpc_pkg::ST_RUN;
            end
            default: begin
                n_state = cbpc_pkg::ST_CLEAR;
            end
        endcase
    end

    // Dividend selection
    always_comb begin
        case (r_div_idx)
            cbpc_pkg::BIN_A:  w_div_cnt = r_cnt.cnt_a;
            cbpc_pkg::BIN_C:  w_div_cnt = r_cnt.cnt_c;
            cbpc_pkg::BIN_G:  w_div_cnt = r_cnt.cnt_g;
            cbpc_pkg::BIN_T:  w_div_cnt = r_cnt.cnt_t;
            default:          w_div_cnt = r_cnt.cnt_o;
        endcase
    end

    cbpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({w_div_cnt, {cbpc_pkg::FRAC_SHIFT{1'b0}}}),
        .i_den   (r_total),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Query capture and fraction collection
    always_ff @(posedge i_clk) begin
        if (r_state == cbpc_pkg::ST_QREAD) begin
            r_cnt     <= w_rd_masked;
            r_total   <= w_sum;
            r_div_idx <= cbpc_pkg::BIN_A;
            for (int i = 0; i < cbpc_pkg::NUM_BINS; i++) begin
                r_frac[i] <= '0;
            end
        end else if (r_state == cbpc_pkg::ST_DIV_WAIT && w_div_done) begin
            r_frac[r_div_idx] <= cbpc_pkg::sat_frac(w_div_quot);
            if (r_div_idx != cbpc_pkg::BIN_OTHER) begin
                r_div_idx <= cbpc_pkg::t_bin'(r_div_idx + 1'b1);
            end
        end
    end

    // Result word
    assign o_valid        = (r_state == cbpc_pkg::ST_REPORT);
    assign o_count_a      = r_cnt.cnt_a;
    assign o_count_c      = r_cnt.cnt_c;
    assign o_count_g      = r_cnt.cnt_g;
    assign o_count_t      = r_cnt.cnt_t;
    assign o_count_other  = r_cnt.cnt_o;
    assign o_base_total   = r_total;
    assign o_frac_a       = cbpc_pkg::FRAC_BASE_W'(r_frac[cbpc_pkg::BIN_A]);
    assign o_frac_c       = cbpc_pkg::FRAC_BASE_W'(r_frac[cbpc_pkg::BIN_C]);
    assign o_frac_g       = cbpc_pkg::FRAC_BASE_W'(r_frac[cbpc_pkg::BIN_G]);
    assign o_frac_t       = cbpc_pkg::FRAC_BASE_W'(r_frac[cbpc_pkg::BIN_T]);
    assign o_frac_other   = r_frac[cbpc_pkg::BIN_OTHER];
    assign o_in_last_line = r_in_last;

endmodule

FILE: bench/column_base_profile_counter_top_tb.sv
// Self-checking bench for the column base profile counter: directed table and random text.
`timescale 1ns / 100ps

module column_base_profile_counter_top_tb;
    import cbpc_pkg::*;

    localparam int          DEPTH        = DEF_MAX_COLUMNS;
    localparam logic [10:0] END_COL      = 11'(DEPTH);
    localparam logic [1:0]  MODE_SPARE   = 2'd3;
    localparam int          RANDOM_WORDS = 1875;
    localparam int          CYCLE_LIMIT  = 4_000_000;

    // One query report, field for field as on the result ports
    typedef struct packed {
        logic [CNT_W-1:0]       cnt_a;
        logic [CNT_W-1:0]       cnt_c;
        logic [CNT_W-1:0]       cnt_g;
        logic [CNT_W-1:0]       cnt_t;
        logic [CNT_W-1:0]       cnt_o;
        logic [TOTAL_W-1:0]     total;
        logic [FRAC_BASE_W-1:0] fr_a;
        logic [FRAC_BASE_W-1:0] fr_c;
        logic [FRAC_BASE_W-1:0] fr_g;
        logic [FRAC_BASE_W-1:0] fr_t;
        logic [FRAC_W-1:0]      fr_o;
        logic                   in_last;
    } report_t;

    // Directed stimulus row; typed rows carry their report written out by hand
    typedef struct {
        logic [1:0]        mode;
        logic [7:0]        sym;
        logic [QCOL_W-1:0] qcol;
        bit                typed;
        report_t           want;
    } dir_row_t;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   start          = 1'b0;
    logic [1:0]             i_mode         = MODE_SYMBOL;
    logic [7:0]             i_symbol       = 8'h00;
    logic [QCOL_W-1:0]      i_query_column = '0;
    logic                   busy;
    logic                   o_valid;
    logic [CNT_W-1:0]       o_count_a, o_count_c, o_count_g, o_count_t, o_count_other;
    logic [TOTAL_W-1:0]     o_base_total;
    logic [FRAC_BASE_W-1:0] o_frac_a, o_frac_c, o_frac_g, o_frac_t;
    logic [FRAC_W-1:0]      o_frac_other;
    logic                   o_in_last_line;

    // Model state: per-column tallies, column position, last closed line length
    logic [CNT_W-1:0] tally [NUM_BINS][DEPTH];
    logic [10:0]      col_pos  = '0;
    logic [10:0]      last_len = '0;

    report_t  pending_reports [$];
    dir_row_t dir_rows [$];
    int       errors      = 0;
    int       words_taken = 0;
    int       cycles      = 0;

    column_base_profile_counter_top #(
        .MAX_COLUMNS(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_symbol      (i_symbol),
        .i_query_column(i_query_column),
        .o_valid       (o_valid),
        .o_count_a     (o_count_a),
        .o_count_c     (o_count_c),
        .o_count_g     (o_count_g),
        .o_count_t     (o_count_t),
        .o_count_other (o_count_other),
        .o_base_total  (o_base_total),
        .o_frac_a      (o_frac_a),
        .o_frac_c      (o_frac_c),
        .o_frac_g      (o_frac_g),
        .o_frac_t      (o_frac_t),
        .o_frac_other  (o_frac_other),
        .o_in_last_line(o_in_last_line)
    );

    always #2 i_clk = ~i_clk;

    // Hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d reports outstanding", $time, pending_reports.size());
            $display("column_base_profile_counter_top_tb failed");
            $finish;
        end
    end

    // Count over total in Q8.8, truncated and capped; zero total gives zero
    function automatic logic [FRAC_W-1:0] q88(input logic [CNT_W-1:0] num,
                                              input logic [TOTAL_W-1:0] den,
                                              input logic [FRAC_W-1:0] cap);
        logic [NUM_W-1:0] quot;
        if (den == '0) return '0;
        quot = {num, {FRAC_SHIFT{1'b0}}} / NUM_W'(den);
        return (quot > NUM_W'(cap)) ? cap : quot[FRAC_W-1:0];
    endfunction

    function automatic logic [7:0] base_code(input int k);
        case (k)
            0:       return CH_A;
            1:       return CH_C;
            2:       return CH_G;
            default: return CH_T;
        endcase
    endfunction

    function automatic report_t report(input int a, c, g, t, o, tot,
                                       input int fa, fc, fg, ft, fo, inl);
        report_t r;
        r.cnt_a   = CNT_W'(a);
        r.cnt_c   = CNT_W'(c);
        r.cnt_g   = CNT_W'(g);
        r.cnt_t   = CNT_W'(t);
        r.cnt_o   = CNT_W'(o);
        r.total   = TOTAL_W'(tot);
        r.fr_a    = FRAC_BASE_W'(fa);
        r.fr_c    = FRAC_BASE_W'(fc);
        r.fr_g    = FRAC_BASE_W'(fg);
        r.fr_t    = FRAC_BASE_W'(ft);
        r.fr_o    = FRAC_W'(fo);
        r.in_last = inl[0];
        return r;
    endfunction

    // Query column: half where short lines land, else line-length edges, top column or random
    function automatic logic [QCOL_W-1:0] pick_col();
        int          pick;
        logic [10:0] lim;
        lim  = (last_len > 11'd1023) ? 11'd1023 : last_len;
        pick = $urandom_range(0, 9);
        if (pick < 5) return QCOL_W'($urandom_range(0, 24));
        if (pick == 5) return lim[QCOL_W-1:0];
        if (pick == 6) return (lim == '0) ? '0 : QCOL_W'(lim - 11'd1);
        if (pick == 7) return '1;
        return QCOL_W'($urandom);
    endfunction

    // Advance the model by one word; a query yields the expected report
    task automatic profile_step(input logic [1:0] m, input logic [7:0] s,
                                input logic [QCOL_W-1:0] q, output bit has,
                                output report_t r);
        logic [7:0]         folded;
        t_bin               bin;
        logic [CNT_W-1:0]   cnt [NUM_BINS];
        logic [TOTAL_W-1:0] tot;
        int                 b;
        has = 1'b0;
        r   = '0;
        case (m)
            MODE_SYMBOL: begin
                if (col_pos >= END_COL) begin
                    // past the store: dropped, position pinned
                    col_pos = END_COL;
                end else begin
                    folded = (s >= CH_LOWER_A && s <= CH_LOWER_Z) ? s - CASE_BIT : s;
                    case (folded)
                        CH_A:    bin = BIN_A;
                        CH_C:    bin = BIN_C;
                        CH_G:    bin = BIN_G;
                        CH_T:    bin = BIN_T;
                        default: bin = BIN_OTHER;
                    endcase
                    if (tally[bin][col_pos[QCOL_W-1:0]] != '1)
                        tally[bin][col_pos[QCOL_W-1:0]] =
                            tally[bin][col_pos[QCOL_W-1:0]] + 1'b1;
                    col_pos = col_pos + 11'd1;
                end
            end
            MODE_EOL: begin
                last_len = col_pos;
                col_pos  = '0;
            end
            MODE_QUERY: begin
                for (b = 0; b < NUM_BINS; b++)
                    cnt[b] = ({1'b0, q} < END_COL) ? tally[b][q] : '0;
                tot = TOTAL_W'(cnt[BIN_A]) + TOTAL_W'(cnt[BIN_C])
                    + TOTAL_W'(cnt[BIN_G]) + TOTAL_W'(cnt[BIN_T]);
                r.cnt_a   = cnt[BIN_A];
                r.cnt_c   = cnt[BIN_C];
                r.cnt_g   = cnt[BIN_G];
                r.cnt_t   = cnt[BIN_T];
                r.cnt_o   = cnt[BIN_OTHER];
                r.total   = tot;
                r.fr_a    = FRAC_BASE_W'(q88(cnt[BIN_A], tot, 16'd256));
                r.fr_c    = FRAC_BASE_W'(q88(cnt[BIN_C], tot, 16'd256));
                r.fr_g    = FRAC_BASE_W'(q88(cnt[BIN_G], tot, 16'd256));
                r.fr_t    = FRAC_BASE_W'(q88(cnt[BIN_T], tot, 16'd256));
                r.fr_o    = q88(cnt[BIN_OTHER], tot, '1);
                r.in_last = ({1'b0, q} < last_len);
                has       = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Drive one word, wait for it to be taken, then maybe idle a while
    task automatic send(input logic [1:0] m, input logic [7:0] s,
                        input logic [QCOL_W-1:0] q, input bit typed, input report_t fixed);
        bit      has;
        report_t r;
        int      gap;
        int      pick;
        start          <= 1'b1;
        i_mode         <= m;
        i_symbol       <= s;
        i_query_column <= q;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        profile_step(m, s, q, has, r);
        if (m != MODE_SPARE) words_taken++;
        if (has) pending_reports.push_back(typed ? fixed : r);
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (pick >= 92)      gap = $urandom_range(4, 40);
        else if (pick >= 60) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every report is back
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic add_row(input logic [1:0] m, input logic [7:0] s,
                           input logic [QCOL_W-1:0] q, input bit typed, input report_t want);
        dir_row_t row;
        row.mode  = m;
        row.sym   = s;
        row.qcol  = q;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each strobed report with the oldest expected one
    always @(posedge i_clk) begin
        report_t want;
        if (i_rst_n && o_valid) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: report strobed with none expected", $time);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                check_field("count_a", 32'(want.cnt_a), 32'(o_count_a));
                check_field("count_c", 32'(want.cnt_c), 32'(o_count_c));
                check_field("count_g", 32'(want.cnt_g), 32'(o_count_g));
                check_field("count_t", 32'(want.cnt_t), 32'(o_count_t));
                check_field("count_other", 32'(want.cnt_o), 32'(o_count_other));
                check_field("base_total", 32'(want.total), 32'(o_base_total));
                check_field("frac_a", 32'(want.fr_a), 32'(o_frac_a));
                check_field("frac_c", 32'(want.fr_c), 32'(o_frac_c));
                check_field("frac_g", 32'(want.fr_g), 32'(o_frac_g));
                check_field("frac_t", 32'(want.fr_t), 32'(o_frac_t));
                check_field("frac_other", 32'(want.fr_o), 32'(o_frac_other));
                check_field("in_last_line", 32'(want.in_last), 32'(o_in_last_line));
            end
        end
    end

    initial begin
        int         b, c, j, len, line_no, pick, base;
        logic [7:0] sym;

        for (b = 0; b < NUM_BINS; b++)
            for (c = 0; c < DEPTH; c++)
                tally[b][c] = '0;

        // Directed: empty store, case folding edges, zero total, line boundaries
        add_row(MODE_QUERY, 8'h00, 10'd0, 1, report(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(MODE_QUERY, 8'hFF, 10'd1023, 1, report(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(MODE_SYMBOL, CH_A, 10'h3FF, 0, '0);
        add_row(MODE_SYMBOL, 8'h63, 10'h000, 0, '0);    // c
        add_row(MODE_SYMBOL, CH_G, 10'h155, 0, '0);
        add_row(MODE_SYMBOL, 8'h74, 10'h2AA, 0, '0);    // t
        add_row(MODE_SYMBOL, 8'h7A, 10'h000, 0, '0);    // z folds but is no base
        add_row(MODE_SYMBOL, 8'h60, 10'h000, 0, '0);    // just below a
        add_row(MODE_SYMBOL, 8'h7B, 10'h000, 0, '0);    // just above z
        add_row(MODE_SYMBOL, 8'hE1, 10'h000, 0, '0);    // a with the top bit set
        add_row(MODE_SYMBOL, 8'hFF, 10'h000, 0, '0);
        add_row(MODE_SYMBOL, 8'h00, 10'h000, 0, '0);
        add_row(MODE_EOL, 8'hFF, 10'h3FF, 0, '0);
        add_row(MODE_QUERY, 8'h00, 10'd0, 1, report(1, 0, 0, 0, 0, 1, 256, 0, 0, 0, 0, 1));
        add_row(MODE_QUERY, 8'h00, 10'd1, 1, report(0, 1, 0, 0, 0, 1, 0, 256, 0, 0, 0, 1));
        add_row(MODE_QUERY, 8'h00, 10'd3, 1, report(0, 0, 0, 1, 0, 1, 0, 0, 0, 256, 0, 1));
        add_row(MODE_QUERY, 8'h00, 10'd6, 1, report(0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1));
        add_row(MODE_QUERY, 8'h00, 10'd9, 1, report(0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1));
        add_row(MODE_QUERY, 8'h00, 10'd10, 1, report(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(MODE_SPARE, 8'hFF, 10'h3FF, 0, '0);
        add_row(MODE_SYMBOL, 8'h67, 10'h000, 0, '0);    // g, new line left open
        add_row(MODE_QUERY, 8'h00, 10'd0, 0, '0);
        add_row(MODE_EOL, 8'h00, 10'h000, 0, '0);
        add_row(MODE_QUERY, 8'h00, 10'd1, 1, report(0, 1, 0, 0, 0, 1, 0, 256, 0, 0, 0, 0));
        add_row(MODE_QUERY, 8'h00, 10'd2, 0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send(dir_rows[i].mode, dir_rows[i].sym, dir_rows[i].qcol,
                 dir_rows[i].typed, dir_rows[i].want);

        drain();

        // Random text: short lines, one line running past the store, some left open
        base    = words_taken;
        line_no = 0;
        while (words_taken - base < RANDOM_WORDS) begin
            line_no++;
            len = (line_no == 3) ? $urandom_range(DEPTH + 1, DEPTH + 16) : $urandom_range(0, 24);
            for (j = 0; j < len; j++) begin
                if ($urandom_range(0, 31) == 0)
                    send(MODE_QUERY, 8'($urandom), pick_col(), 1'b0, '0);
                if ($urandom_range(0, 31) == 0)
                    send(MODE_SPARE, 8'($urandom), QCOL_W'($urandom), 1'b0, '0);
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    sym = base_code($urandom_range(0, 3));
                    if ($urandom_range(0, 1) == 1) sym |= CASE_BIT;
                end else if (pick == 6) begin
                    sym = 8'($urandom_range(CH_A, CH_LOWER_Z));
                end else begin
                    sym = 8'($urandom);
                end
                send(MODE_SYMBOL, sym, QCOL_W'($urandom), 1'b0, '0);
            end
            if ($urandom_range(0, 9) != 0)
                send(MODE_EOL, 8'($urandom), QCOL_W'($urandom), 1'b0, '0);
            repeat ($urandom_range(0, 2))
                send(MODE_QUERY, 8'($urandom), pick_col(), 1'b0, '0);
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("column_base_profile_counter_top_tb passed");
        end else begin
            $display("column_base_profile_counter_top_tb failed");
        end
        $finish;
    end

endmodule

FILE: column_base_profile_counter_top.f
rtl/cbpc_pkg.sv
rtl/cbpc_ram.sv
rtl/cbpc_div.sv
rtl/column_base_profile_counter_top.sv
bench/column_base_profile_counter_top_tb.sv
